>>> hw/rtl/swdel_pkg.sv
`default_nettype none

package swdel_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 5;

  // Data word returned by pop and peek on an empty stack.
  localparam logic [WORD_W-1:0] WORD_EMPTY = '1;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [WORD_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  data;
    status_e                   status;
    logic [COUNT_W-1:0]        count;
  } out_t;

endpackage

`default_nettype wire

>>> hw/rtl/stack_with_delete_by_value.sv
// The sequencer takes each input beat through its states: a push writes the RAM, a pop or peek
// reads the top entry through the storage RAM's registered read, and a delete reads and compares
// entries from the top down, then reads and writes each entry above the hit to move it down. One
// item is in work at a time; the next input beat is taken once the result has moved to the output
// register. Reset clears control state and the entry count.
`default_nettype none

module stack_with_delete_by_value #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire swdel_pkg::in_t   in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output swdel_pkg::out_t       out_o
);

  import swdel_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  // Result handoff from the sequencer into the output register.
  logic              res_valid;
  logic              res_ready;
  out_t              res;

  // Storage RAM port.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              out_valid_q;
  out_t              out_q;

  swdel_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // The stack words live in one RAM; entry 0 is the bottom of the stack.
  swdel_ram #(
    .Width(WORD_W),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register takes a new result whenever it is empty or its beat leaves this
  // cycle, so the sequencer can go back to idle and take the next item while a result waits.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/swdel_ram.sv
`default_nettype none

module swdel_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/swdel_ctrl.sv
`default_nettype none

module swdel_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire swdel_pkg::in_t                 in_i,
  output logic                                res_valid_o,
  output swdel_pkg::out_t                     res_o,
  input  wire logic                           res_ready_i,
  output logic                                ram_we_o,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr_o,
  output logic [swdel_pkg::WORD_W-1:0]        ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr_o,
  input  wire logic [swdel_pkg::WORD_W-1:0]   ram_rdata_i
);

  import swdel_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e              state_q, state_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic [AW-1:0]       idx_q, idx_d;
  mode_e               mode_q, mode_d;
  logic [WORD_W-1:0]   val_q, val_d;
  out_t                res_q, res_d;

  logic                empty, full, match, shift_more;
  logic [CW-1:0]       fill_inc, fill_dec, idx_next;

  // The count field is the fill level taken modulo 32.
  function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] f);
    logic [CW+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, f};
    return w[COUNT_W-1:0];
  endfunction

  assign empty      = (fill_q == '0);
  assign full       = (fill_q == CW'(DEPTH));
  assign fill_inc   = fill_q + CW'(1);
  assign fill_dec   = fill_q - CW'(1);
  assign idx_next   = CW'(idx_q) + CW'(1);
  assign match      = (ram_rdata_i == val_q);
  assign shift_more = (idx_next < fill_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_q)
          MODE_PUSH:               state_d = S_DONE;
          MODE_POP, MODE_PEEK:     state_d = empty ? S_DONE : S_RDWAIT;
          MODE_DELETE:             state_d = empty ? S_DONE : S_SRCH_RD;
          default:                 state_d = S_DONE;
        endcase
      end
      S_RDWAIT:   state_d = S_DONE;
      S_SRCH_RD:  state_d = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (match) begin
          state_d = S_SHIFT_RD;
        end else if (idx_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: state_d = shift_more ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    mode_d      = mode_q;
    val_d       = val_q;
    res_d       = res_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d = in_i.mode;
          val_d  = in_i.value;
        end
      end
      S_EXEC: begin
        res_d.data   = '0;
        res_d.status = STAT_OK;
        case (mode_q)
          MODE_PUSH: begin
            if (full) begin
              res_d.status = STAT_FULL;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = fill_q[AW-1:0];
              ram_wdata_o = val_q;
              fill_d      = fill_inc;
            end
          end
          MODE_POP, MODE_PEEK: begin
            if (empty) begin
              res_d.data   = WORD_EMPTY;
              res_d.status = STAT_EMPTY;
            end else begin
              ram_re_o    = 1'b1;
              ram_raddr_o = fill_dec[AW-1:0];
            end
          end
          MODE_DELETE: begin
            if (empty) begin
              res_d.status = STAT_EMPTY;
            end else begin
              idx_d = fill_dec[AW-1:0];
            end
          end
          default: ;
        endcase
      end
      S_RDWAIT: begin
        res_d.data = ram_rdata_i;
        if (mode_q == MODE_POP) begin
          fill_d = fill_dec;
        end
      end
      S_SRCH_RD: begin
        ram_re_o = 1'b1;
      end
      S_SRCH_CMP: begin
        if (!match) begin
          if (idx_q == '0) begin
            res_d.status = STAT_NOTFOUND;
          end else begin
            idx_d = idx_q - AW'(1);
          end
        end
      end
      S_SHIFT_RD: begin
        if (shift_more) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_next[AW-1:0];
        end else begin
          fill_d = fill_dec;
        end
      end
      S_SHIFT_WR: begin
        ram_we_o = 1'b1;
        idx_d    = idx_next[AW-1:0];
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
    res_d.count = to_count(fill_d);
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    mode_q <= mode_d;
    val_q  <= val_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

>>> tb/stack_with_delete_by_value_checker.sv
`timescale 1ns / 1ps

module stack_with_delete_by_value_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  swdel_pkg::in_t  in_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  swdel_pkg::out_t out_i,
  output int              fail_count_o,
  output int              in_beats_o,
  output int              out_beats_o,
  output int              full_drops_o,
  output int              delete_misses_o
);

  import swdel_pkg::*;

  // Shadow copy of the stack; index 0 is the bottom entry.
  logic [WORD_W-1:0] stack_words [DEPTH];
  int unsigned       stack_fill;
  out_t              expected_results [$];
  out_t              got_result;
  out_t              want_result;
  int                field_errs;

  function automatic out_t predict_stack_result(in_t beat);
    out_t        res;
    int unsigned hit_pos;
    bit          found;
    res.data   = '0;
    res.status = STAT_OK;
    hit_pos    = 0;
    found      = 1'b0;
    case (beat.mode)
      MODE_PUSH: begin
        if (stack_fill >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          stack_words[stack_fill] = beat.value;
          stack_fill++;
        end
      end
      MODE_POP: begin
        if (stack_fill == 0) begin
          res.data   = WORD_EMPTY;
          res.status = STAT_EMPTY;
        end else begin
          stack_fill--;
          res.data = stack_words[stack_fill];
        end
      end
      MODE_PEEK: begin
        if (stack_fill == 0) begin
          res.data   = WORD_EMPTY;
          res.status = STAT_EMPTY;
        end else begin
          res.data = stack_words[stack_fill-1];
        end
      end
      default: begin
        if (stack_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          // Search from the top down; the first match wins.
          for (int k = int'(stack_fill) - 1; k >= 0; k--) begin
            if (!found && stack_words[k] == beat.value) begin
              found   = 1'b1;
              hit_pos = k;
            end
          end
          if (!found) begin
            res.status = STAT_NOTFOUND;
          end else begin
            for (int unsigned j = hit_pos; j + 1 < stack_fill; j++) begin
              stack_words[j] = stack_words[j+1];
            end
            stack_fill--;
          end
        end
      end
    endcase
    res.count = COUNT_W'(stack_fill);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_fill = 0;
      expected_results.delete();
      fail_count_o    <= 0;
      in_beats_o      <= 0;
      out_beats_o     <= 0;
      full_drops_o    <= 0;
      delete_misses_o <= 0;
    end else begin
      // The result side is handled first, so a result beat never meets an
      // expectation queued on the same edge.
      if (out_valid_i && out_ready_i) begin
        got_result = out_i;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: data %0d status %0d count %0d",
                   $time, got_result.data, got_result.status, got_result.count);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want_result = expected_results.pop_front();
          field_errs  = 0;
          if (got_result.data !== want_result.data) begin
            $display("%0t: data mismatch: expected %0d, actual %0d",
                     $time, want_result.data, got_result.data);
            field_errs++;
          end
          if (got_result.status !== want_result.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want_result.status, got_result.status);
            field_errs++;
          end
          if (got_result.count !== want_result.count) begin
            $display("%0t: count mismatch: expected %0d, actual %0d",
                     $time, want_result.count, got_result.count);
            field_errs++;
          end
          fail_count_o <= fail_count_o + field_errs;
        end
        out_beats_o <= out_beats_o + 1;
      end
      if (in_valid_i && in_ready_i) begin
        want_result = predict_stack_result(in_i);
        if (want_result.status == STAT_FULL) begin
          full_drops_o <= full_drops_o + 1;
        end
        if (want_result.status == STAT_NOTFOUND) begin
          delete_misses_o <= delete_misses_o + 1;
        end
        expected_results.push_back(want_result);
        in_beats_o <= in_beats_o + 1;
      end
    end
  end

endmodule

>>> tb/stack_with_delete_by_value_tb.sv
`timescale 1ns / 1ps

module stack_with_delete_by_value_tb;
  import swdel_pkg::*;

  localparam int unsigned STACK_DEPTH  = 16;
  // Least number of beats in the random part of the run.
  localparam int unsigned RANDOM_BEATS = 1350;
  // Result beat count at which the receiver starts its one long hold-off.
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned LONG_HOLD    = 400;
  // The slowest correct stretch without a beat is the long hold-off plus a
  // worst-case delete; the watchdog allows several times that.
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_o;

  int fail_count;
  int in_beats;
  int out_beats;
  int full_drops;
  int delete_misses;

  // Stimulus bookkeeping: beats offered per operation and a ring of recently
  // pushed words, used to aim deletes at words that are likely on the stack.
  int                mode_sent [4];
  int                total_sent;
  logic [WORD_W-1:0] recent_words [STACK_DEPTH];
  int                recent_wr;
  bit                mid_pause_done;

  // Receiver state.
  int run_left;
  int hold_left;
  bit ready_level;
  bit hold_done;

  int idle_cycles;
  int phase_kind;

  stack_with_delete_by_value #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  stack_with_delete_by_value_checker #(
    .DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_i           (in_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_i          (out_o),
    .fail_count_o   (fail_count),
    .in_beats_o     (in_beats),
    .out_beats_o    (out_beats),
    .full_drops_o   (full_drops),
    .delete_misses_o(delete_misses)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Most gaps are zero or a few cycles; now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Push words mix small values (so duplicates pile up for delete), the
  // corner words of the signed range, repeats of recent pushes and noise.
  function automatic logic [WORD_W-1:0] pick_push_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return WORD_W'($urandom_range(0, 7));
    if (r < 45) begin
      case ($urandom_range(0, 4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    if (r < 55) return recent_words[$urandom_range(0, STACK_DEPTH-1)];
    return $urandom;
  endfunction

  // Delete targets mostly come from recent pushes so that most deletes hit,
  // sometimes deep in the stack; the rest are likely misses.
  function automatic logic [WORD_W-1:0] pick_delete_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return recent_words[$urandom_range(0, STACK_DEPTH-1)];
    if (r < 80) return WORD_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  // Operation mix per phase: balanced, filling and draining.
  function automatic mode_e pick_mode(int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      1: begin
        if (r < 70) return MODE_PUSH;
        if (r < 75) return MODE_POP;
        if (r < 85) return MODE_PEEK;
        return MODE_DELETE;
      end
      2: begin
        if (r < 15) return MODE_PUSH;
        if (r < 55) return MODE_POP;
        if (r < 65) return MODE_PEEK;
        return MODE_DELETE;
      end
      default: begin
        if (r < 35) return MODE_PUSH;
        if (r < 55) return MODE_POP;
        if (r < 70) return MODE_PEEK;
        return MODE_DELETE;
      end
    endcase
  endfunction

  // Offers one beat and returns at the falling edge after it is accepted.
  // It is always entered at a falling edge. With a zero gap valid simply
  // stays high, so it is never dropped and raised in the same step.
  task automatic drive_beat(input mode_e op, input logic [WORD_W-1:0] word);
    int   gap;
    in_t  beat;
    gap        = pick_gap();
    beat.mode  = op;
    beat.value = word;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    mode_sent[op] = mode_sent[op] + 1;
    total_sent    = total_sent + 1;
    if (op == MODE_PUSH) begin
      recent_words[recent_wr] = word;
      recent_wr = (recent_wr + 1) % STACK_DEPTH;
    end
    @(negedge clk_i);
  endtask

  // The sender stops offering and waits until every result is back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    wait (out_beats == in_beats);
    @(negedge clk_i);
  endtask

  // Receiver: runs of ready, short and occasional long stalls, and one long
  // hold-off while the sender keeps offering, so the block backs up and its
  // input stalls.
  initial begin
    out_ready_i = 1'b0;
    run_left    = 0;
    hold_left   = 0;
    ready_level = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left   = hold_left - 1;
      end else if (!hold_done && out_beats >= HOLD_AT) begin
        hold_done   = 1'b1;
        hold_left   = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 19))
            0:           begin ready_level = 1'b0; run_left = $urandom_range(8, 40); end
            1, 2, 3, 4,
            5, 6, 7:     begin ready_level = 1'b0; run_left = $urandom_range(1, 3); end
            default:     begin ready_level = 1'b1; run_left = $urandom_range(1, 30); end
          endcase
        end
        out_ready_i <= ready_level;
        run_left    = run_left - 1;
      end
    end
  end

  // Watchdog: any stretch of cycles without a beat on either side that is
  // longer than the limit ends the run.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
    end
    $display("%0t: watchdog: no beat for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, in_beats - out_beats);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_i           = '0;
    total_sent     = 0;
    recent_wr      = 0;
    mid_pause_done = 1'b0;
    for (int m = 0; m < 4; m++) mode_sent[m] = 0;
    for (int k = 0; k < STACK_DEPTH; k++) recent_words[k] = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. The empty stack first: pop, peek and delete all report
    // empty, and pop and peek return all ones.
    drive_beat(MODE_POP,    32'hFFFF_FFFF);
    drive_beat(MODE_PEEK,   32'h0000_0000);
    drive_beat(MODE_DELETE, 32'h0000_0000);
    // Corner words of the signed range, then a value pushed twice.
    drive_beat(MODE_PUSH,   32'h8000_0000);
    drive_beat(MODE_PUSH,   32'h7FFF_FFFF);
    drive_beat(MODE_PUSH,   32'hFFFF_FFFF);
    drive_beat(MODE_PUSH,   32'h0000_0000);
    drive_beat(MODE_PUSH,   32'h0000_0005);
    drive_beat(MODE_PUSH,   32'h0000_0007);
    drive_beat(MODE_PUSH,   32'h0000_0005);
    drive_beat(MODE_PEEK,   32'hA5A5_5A5A);
    // Two entries hold 5; only the upper one may go.
    drive_beat(MODE_DELETE, 32'h0000_0005);
    // A value that is not on the stack.
    drive_beat(MODE_DELETE, 32'h0000_002A);
    // Deleting the bottom entry moves every other entry down.
    drive_beat(MODE_DELETE, 32'h8000_0000);
    drive_beat(MODE_PEEK,   32'h0000_0000);
    drive_beat(MODE_POP,    32'h5A5A_A5A5);
    drive_beat(MODE_DELETE, 32'hFFFF_FFFF);
    // Differs from the bottom entry in one bit only, so it must miss.
    drive_beat(MODE_DELETE, 32'h7FFF_FFFE);
    drive_beat(MODE_POP,    32'h0000_0000);
    drive_beat(MODE_POP,    32'h0000_0000);
    drive_beat(MODE_POP,    32'h0000_0000);
    drive_beat(MODE_POP,    32'h0000_0000);
    drive_beat(MODE_PEEK,   32'hFFFF_FFFF);
    wait_drained();

    // Random part, in phases. Phase 3 fills the stack past full, so pushes
    // are dropped, and then digs into it with deletes that often hit deep
    // entries and shift long runs of words.
    while (total_sent < 23 + RANDOM_BEATS) begin
      phase_kind = $urandom_range(0, 3);
      if (phase_kind == 3) begin
        repeat (STACK_DEPTH + 2) drive_beat(MODE_PUSH, pick_push_word());
        repeat (8) drive_beat(MODE_DELETE, pick_delete_word());
        repeat (4) drive_beat(MODE_POP, $urandom);
      end else begin
        repeat (40) begin
          case (pick_mode(phase_kind))
            MODE_PUSH:   drive_beat(MODE_PUSH, pick_push_word());
            MODE_POP:    drive_beat(MODE_POP, $urandom);
            MODE_PEEK:   drive_beat(MODE_PEEK, $urandom);
            default:     drive_beat(MODE_DELETE, pick_delete_word());
          endcase
        end
      end
      // Once in the middle of the run the sender lets the block drain fully.
      if (!mid_pause_done && total_sent >= 700) begin
        mid_pause_done = 1'b1;
        wait_drained();
      end
    end

    // Drain: wait for every result, then give the block time to show any
    // stray result beat.
    in_valid_i <= 1'b0;
    wait (out_beats == in_beats);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d beats: %0d push, %0d pop, %0d peek, %0d delete.",
             total_sent, mode_sent[MODE_PUSH], mode_sent[MODE_POP],
             mode_sent[MODE_PEEK], mode_sent[MODE_DELETE]);
    $display("Checked %0d results, %0d pushes dropped at full, %0d delete misses, %0d errors.",
             out_beats, full_drops, delete_misses, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/swdel_pkg.sv
hw/rtl/swdel_ram.sv
hw/rtl/swdel_ctrl.sv
hw/rtl/stack_with_delete_by_value.sv
tb/stack_with_delete_by_value_checker.sv
tb/stack_with_delete_by_value_tb.sv
